// ===== rtl/core/line_editor_erase_kill_assert.svh =====
// assertion macros used by the line editor back end
`ifndef LINE_EDITOR_ERASE_KILL_ASSERT_SVH
`define LINE_EDITOR_ERASE_KILL_ASSERT_SVH

// condition must hold in the same cycle as the trigger
`define LEE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition must hold in the cycle after the trigger
`define LEE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/lee_pkg.sv =====
package lee_pkg;

  // special input bytes
  localparam logic [7:0] CH_ERASE   = 8'h23;
  localparam logic [7:0] CH_KILL    = 8'h40;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  // command codes passed from front to back
  typedef logic [1:0] op_t;
  localparam op_t OP_APPEND  = 2'd0;
  localparam op_t OP_ERASE   = 2'd1;
  localparam op_t OP_KILL    = 2'd2;
  localparam op_t OP_NEWLINE = 2'd3;

  typedef struct packed {
    op_t        op;
    logic [7:0] ch;
  } cmd_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       dropped;
  } res_t;

  // command queue between front and back
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = 1;
  localparam int CMDQ_CNT_W = 2;

  // result queue at the output
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_PTR_W = 2;
  localparam int OUTQ_CNT_W = 3;

endpackage

// ===== rtl/core/line_editor_erase_kill.sv =====
// Line editor with erase and kill.
// Input side is a queue: present a typed byte on in_char with push; it is
// taken on a clock edge where push is high and full is low. '#' erases the
// last buffered character, '@' clears the line, a newline emits the line.
// Result side is a queue: while empty is low the oldest result sits on
// out_char/out_last/out_dropped and is taken on an edge with pop high.
// A newline yields the buffered characters in typed order, then the newline
// with out_last set; out_dropped marks every result of a line that lost
// characters to a full buffer (LINE_DEPTH entries).
// Throughput: one byte per cycle for ordinary, erase and kill bytes while the
// back end is idle, set by the single command decode in the back end. A
// newline keeps the back end busy while it reads out the line, one buffer
// read per cycle while the result queue has room; meanwhile the two-entry
// command queue absorbs input, then full rises.
// A queued newline is taken by the idle back end; buffer reads are registered.
// If the receiver stalls, the four-entry result queue fills, emission pauses,
// and the command queue backs up to full.
// Reset: buffer empties, dropped mark clears, both queues are empty; the
// buffer contents are not cleared and need no clearing pass.
module line_editor_erase_kill #(
  parameter int LINE_DEPTH = 63
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  logic [7:0]  in_char,
  output logic        full,
  input  logic        pop,
  output logic        empty,
  output logic [7:0]  out_char,
  output logic        out_last,
  output logic        out_dropped
);

  logic             cmd_valid;
  lee_pkg::cmd_t    cmd;
  logic             cmd_pop;

  // byte intake and classification
  lee_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .in_char   (in_char),
    .full      (full),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  // line buffer and result emission
  lee_back #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop),
    .pop         (pop),
    .empty       (empty),
    .out_char    (out_char),
    .out_last    (out_last),
    .out_dropped (out_dropped)
  );

endmodule

// ===== rtl/core/lee_front.sv =====
module lee_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [7:0]       in_char,
  output logic             full,
  output logic             cmd_valid,
  output lee_pkg::cmd_t    cmd,
  input  logic             cmd_pop
);

  lee_pkg::cmd_t                    q_r [lee_pkg::CMDQ_DEPTH];
  logic [lee_pkg::CMDQ_PTR_W-1:0]   wr_ptr_r;
  logic [lee_pkg::CMDQ_PTR_W-1:0]   rd_ptr_r;
  logic [lee_pkg::CMDQ_CNT_W-1:0]   cnt_r;
  logic [lee_pkg::CMDQ_CNT_W-1:0]   cnt_nxt;
  lee_pkg::cmd_t                    cls;
  logic                             wr_en;
  logic                             rd_en;

  // classify the typed byte
  always_comb begin
    cls.ch = in_char;
    case (in_char)
      lee_pkg::CH_ERASE:   cls.op = lee_pkg::OP_ERASE;
      lee_pkg::CH_KILL:    cls.op = lee_pkg::OP_KILL;
      lee_pkg::CH_NEWLINE: cls.op = lee_pkg::OP_NEWLINE;
      default:             cls.op = lee_pkg::OP_APPEND;
    endcase
  end

  // queue status
  assign full      = (cnt_r == lee_pkg::CMDQ_CNT_W'(lee_pkg::CMDQ_DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rd_ptr_r];
  assign wr_en     = push && !full;
  assign rd_en     = cmd_pop && cmd_valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // queue pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// ===== rtl/core/lee_back.sv =====
`include "line_editor_erase_kill_assert.svh"

module lee_back #(
  parameter int LINE_DEPTH = 63
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cmd_valid,
  input  lee_pkg::cmd_t    cmd,
  output logic             cmd_pop,
  input  logic             pop,
  output logic             empty,
  output logic [7:0]       out_char,
  output logic             out_last,
  output logic             out_dropped
);

  localparam int CNT_W  = $clog2(LINE_DEPTH + 1);
  localparam int ADDR_W = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic [7:0]                       line_mem [LINE_DEPTH];
  logic [7:0]                       rd_data_r;
  logic                             inflight_r;
  logic                             state_r;
  logic                             state_nxt;
  logic [CNT_W-1:0]                 fill_r;
  logic [CNT_W-1:0]                 fill_nxt;
  logic [CNT_W-1:0]                 idx_r;
  logic [CNT_W-1:0]                 idx_nxt;
  logic                             ovf_r;
  logic                             ovf_nxt;
  logic                             mem_we;
  logic                             rd_en;
  logic                             nl_push;
  logic                             space;

  lee_pkg::res_t                    oq_r [lee_pkg::OUTQ_DEPTH];
  logic [lee_pkg::OUTQ_PTR_W-1:0]   oq_wr_ptr_r;
  logic [lee_pkg::OUTQ_PTR_W-1:0]   oq_rd_ptr_r;
  logic [lee_pkg::OUTQ_CNT_W-1:0]   oq_cnt_r;
  logic [lee_pkg::OUTQ_CNT_W-1:0]   oq_cnt_nxt;
  logic                             oq_push;
  logic                             oq_pop;
  lee_pkg::res_t                    oq_in;
  lee_pkg::res_t                    oq_head;

  // room in the result queue, counting a read still in flight
  assign space = (oq_cnt_r + lee_pkg::OUTQ_CNT_W'(inflight_r))
                 < lee_pkg::OUTQ_CNT_W'(lee_pkg::OUTQ_DEPTH);

  assign cmd_pop = (state_r == ST_IDLE) && cmd_valid;

  // command execution and line emit sequencing
  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    idx_nxt   = idx_r;
    ovf_nxt   = ovf_r;
    mem_we    = 1'b0;
    rd_en     = 1'b0;
    nl_push   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (cmd_pop) begin
          case (cmd.op)
            lee_pkg::OP_ERASE: begin
              if (fill_r != '0) begin
                fill_nxt = fill_r - 1'b1;
              end
            end
            lee_pkg::OP_KILL: begin
              fill_nxt = '0;
            end
            lee_pkg::OP_NEWLINE: begin
              state_nxt = ST_EMIT;
              idx_nxt   = '0;
            end
            default: begin
              if (fill_r < CNT_W'(LINE_DEPTH)) begin
                mem_we   = 1'b1;
                fill_nxt = fill_r + 1'b1;
              end else begin
                ovf_nxt = 1'b1;
              end
            end
          endcase
        end
      end
      ST_EMIT: begin
        if (idx_r != fill_r) begin
          if (space) begin
            rd_en   = 1'b1;
            idx_nxt = idx_r + 1'b1;
          end
        end else if (!inflight_r &&
                     (oq_cnt_r != lee_pkg::OUTQ_CNT_W'(lee_pkg::OUTQ_DEPTH))) begin
          nl_push   = 1'b1;
          state_nxt = ST_IDLE;
          fill_nxt  = '0;
          ovf_nxt   = 1'b0;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      fill_r     <= '0;
      idx_r      <= '0;
      ovf_r      <= 1'b0;
      inflight_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      fill_r     <= fill_nxt;
      idx_r      <= idx_nxt;
      ovf_r      <= ovf_nxt;
      inflight_r <= rd_en;
    end
  end

  // line buffer memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[fill_r[ADDR_W-1:0]] <= cmd.ch;
    end
    if (rd_en) begin
      rd_data_r <= line_mem[idx_r[ADDR_W-1:0]];
    end
  end

  // result queue entry: buffered character or closing newline
  always_comb begin
    oq_in.dropped = ovf_r;
    if (inflight_r) begin
      oq_in.ch   = rd_data_r;
      oq_in.last = 1'b0;
    end else begin
      oq_in.ch   = lee_pkg::CH_NEWLINE;
      oq_in.last = 1'b1;
    end
  end

  assign oq_push = inflight_r || nl_push;
  assign empty   = (oq_cnt_r == '0);
  assign oq_pop  = pop && !empty;
  assign oq_head = oq_r[oq_rd_ptr_r];

  assign out_char    = oq_head.ch;
  assign out_last    = oq_head.last;
  assign out_dropped = oq_head.dropped;

  always_comb begin
    oq_cnt_nxt = oq_cnt_r;
    if (oq_push && !oq_pop) begin
      oq_cnt_nxt = oq_cnt_r + 1'b1;
    end else if (oq_pop && !oq_push) begin
      oq_cnt_nxt = oq_cnt_r - 1'b1;
    end
  end

  // result queue pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_ptr_r <= '0;
      oq_rd_ptr_r <= '0;
      oq_cnt_r    <= '0;
    end else begin
      if (oq_push) begin
        oq_wr_ptr_r <= oq_wr_ptr_r + 1'b1;
      end
      if (oq_pop) begin
        oq_rd_ptr_r <= oq_rd_ptr_r + 1'b1;
      end
      oq_cnt_r <= oq_cnt_nxt;
    end
  end

  // result queue storage
  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq_r[oq_wr_ptr_r] <= oq_in;
    end
  end

  // checks
  `LEE_ASSERT_NOW(a_fill_bound, 1'b1, fill_r <= CNT_W'(LINE_DEPTH), "fill count beyond depth")
  `LEE_ASSERT_NOW(a_oq_credit, 1'b1,
    (oq_cnt_r + lee_pkg::OUTQ_CNT_W'(inflight_r)) <= lee_pkg::OUTQ_CNT_W'(lee_pkg::OUTQ_DEPTH),
    "result queue overcommitted")
  `LEE_ASSERT_NOW(a_idx_bound, state_r == ST_EMIT, idx_r <= fill_r, "emit index past fill")
  `LEE_ASSERT_NEXT(a_line_end_clear, (state_r == ST_EMIT) && (state_nxt == ST_IDLE),
    (fill_r == '0) && !ovf_r && (state_r == ST_IDLE), "line state not cleared after newline")

endmodule
